/* rtl/core/lcrv_pkg.sv */
// Shared types and constants of the lidar column ring vertical filter.
`timescale 1ns / 1ps
`default_nettype none
package lcrv_pkg;
    localparam int ROW_W     = 6;
    localparam int GAP_W     = 20;
    localparam int ID_W      = 18;
    localparam int COORD_W   = 19;
    localparam int THR_W     = 16;
    localparam int RUN_DEPTH = 64;
    localparam int RUN_AW    = 6;
    localparam int LEN_W     = 7;
    localparam int GK_W      = ROW_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int ROOT_W    = 19;

    localparam logic [GAP_W-1:0] GAP_SAT    = {GAP_W{1'b1}};
    localparam logic [THR_W-1:0] THR_RESET  = 16'd80;
    localparam logic             FUNC_LOAD  = 1'b0;
    localparam logic             FUNC_POINT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_ADD,
        S_ITER,
        S_DECIDE,
        S_START,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;
endpackage
`default_nettype wire

/* rtl/core/lcrv_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lcrv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* rtl/core/lcrv_isqrt.sv */
// Bit-serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lcrv_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [lcrv_pkg::SQ_W-1:0]   i_radicand,
    output logic                             o_busy,
    output logic      [lcrv_pkg::ROOT_W-1:0] o_root
);
    import lcrv_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [SQ_W-1:0]   r_v;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;

    logic [REM_W+1:0]  w_rem2;
    logic [REM_W+1:0]  w_trial;
    logic              w_take;

    // Bring down the next two radicand bits and try root*4+1.
    assign w_rem2  = {r_rem, r_v[SQ_W-1 -: 2]};
    assign w_trial = (REM_W+2)'({r_root, 2'b01});
    assign w_take  = (w_rem2 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == CNT_W'(ROOT_W - 1))) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_v   <= {r_v[SQ_W-3:0], 2'b00};
            r_cnt <= r_cnt + 1'b1;
            if (w_take) begin
                r_rem  <= REM_W'(w_rem2 - w_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(w_rem2);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule
`default_nettype wire

/* rtl/core/lidar_column_ring_vertical_filter.sv */
// Top level of the lidar column ring vertical filter.
// A table load is written in its transfer cycle. A point is squared in its transfer cycle
// and summed in the next, then runs the 19-step square root, overlapped with the gap-table
// walk (one entry a cycle, up to 63 entries), then a decision state and, when a new run
// opens, a start state. Each emitted result passes a read and a load state, as the run-id
// memory read port is registered.
// Reset is synchronous and active low; it clears the run state and sets the threshold to 80.
`timescale 1ns / 1ps
`default_nettype none
module lidar_column_ring_vertical_filter #(
    parameter int ROWS = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Input channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_func,
    input  wire logic [lcrv_pkg::ROW_W-1:0]   i_row,
    input  wire logic [lcrv_pkg::GAP_W-1:0]   i_gap_mm,
    input  wire logic [lcrv_pkg::ID_W-1:0]    i_point_id,
    input  wire logic signed [lcrv_pkg::COORD_W-1:0] i_x_mm,
    input  wire logic signed [lcrv_pkg::COORD_W-1:0] i_y_mm,
    input  wire logic signed [lcrv_pkg::COORD_W-1:0] i_z_mm,
    input  wire logic                         i_last_in_column,
    // Configuration port.
    input  wire logic                         i_cfg_we,
    input  wire logic [lcrv_pkg::THR_W-1:0]   i_cfg_wdata,
    // Output channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [lcrv_pkg::ID_W-1:0]    o_point_id_res,
    output logic                              o_is_vertical,
    output logic                              o_last_of_run
);
    import lcrv_pkg::*;

    localparam int AW = $clog2(ROWS);

    // Control state.
    t_state r_state, n_state;

    // Threshold register.
    logic [THR_W-1:0] r_thr;

    // Captured point fields.
    logic [ROW_W-1:0]          r_row;
    logic [ID_W-1:0]           r_id;
    logic signed [COORD_W-1:0] r_z;
    logic                      r_last;
    logic [SQ_W-1:0]           r_sqx, r_sqy;

    // Gap-table walk.
    logic [GK_W-1:0]  r_gk;
    logic             r_gpend;
    logic             r_gzero;
    logic [GAP_W-1:0] r_gsum;

    // Run state.
    logic [LEN_W-1:0]          r_len;
    logic [ROW_W-1:0]          r_ref_row;
    logic [ROOT_W-1:0]         r_ref_range;
    logic signed [COORD_W-1:0] r_hmax, r_hmin;
    logic                      r_have;

    // Emission control.
    logic [LEN_W-1:0] r_ek;
    logic             r_emit2;
    logic             r_after;

    // Output register.
    logic             r_out_valid;
    logic [ID_W-1:0]  r_out_id;
    logic             r_out_vert;
    logic             r_out_last;

    // Combinational signals.
    logic                      w_in_acc;
    logic                      w_out_take;
    logic                      w_out_free;
    logic signed [SQ_W-1:0]    w_x2, w_y2;
    logic                      w_sq_start;
    logic                      w_sq_busy;
    logic [ROOT_W-1:0]         w_root;
    logic                      w_g_issue;
    logic                      w_g_done;
    logic [GAP_W:0]            w_gadd;
    logic [GAP_W-1:0]          w_grd;
    logic                      w_gap_we;
    logic [ROOT_W-1:0]         w_diff;
    logic                      w_join;
    logic [COORD_W:0]          w_spread;
    logic                      w_vert;
    logic                      w_ek_end;
    logic                      w_final;
    logic                      w_run_we;
    logic [RUN_AW-1:0]         w_run_waddr;
    logic [ID_W-1:0]           w_run_rdata;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_x2 = SQ_W'(i_x_mm) * SQ_W'(i_x_mm);
    assign w_y2 = SQ_W'(i_y_mm) * SQ_W'(i_y_mm);

    // The gap walk reads entries ref_row up to row-1; entries past the table count zero.
    assign w_g_issue = ((r_state == S_SQ_ADD) || (r_state == S_ITER)) &&
                       (r_gk < {1'b0, r_row});
    assign w_g_done  = !(r_gk < {1'b0, r_row}) && !r_gpend;
    assign w_gadd    = {1'b0, r_gsum} + {1'b0, (r_gzero ? '0 : w_grd)};

    assign w_gap_we = w_in_acc && (i_func == FUNC_LOAD) && (32'(i_row) < ROWS);

    // A point joins the open run when its range step is below the summed gaps and the run is not full.
    assign w_diff = (r_ref_range > w_root) ? (r_ref_range - w_root) : (w_root - r_ref_range);
    assign w_join = r_have && ({1'b0, w_diff} < r_gsum) && (r_len < LEN_W'(RUN_DEPTH));

    // Spread of the run's heights; max is never below min, so it is non-negative.
    assign w_spread = {r_hmax[COORD_W-1], r_hmax} - {r_hmin[COORD_W-1], r_hmin};
    assign w_vert   = (r_len > LEN_W'(1)) && (w_spread > (COORD_W+1)'(r_thr));

    assign w_ek_end = (r_ek == (r_len - 1'b1));
    assign w_final  = w_ek_end && !r_emit2;

    lcrv_ram #(
        .WIDTH (GAP_W),
        .DEPTH (ROWS)
    ) u_gap_ram (
        .i_clk   (i_clk),
        .i_we    (w_gap_we),
        .i_waddr (AW'(i_row)),
        .i_wdata (i_gap_mm),
        .i_raddr (AW'(r_gk)),
        .o_rdata (w_grd)
    );

    lcrv_ram #(
        .WIDTH (ID_W),
        .DEPTH (RUN_DEPTH)
    ) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (w_run_we),
        .i_waddr (w_run_waddr),
        .i_wdata (r_id),
        .i_raddr (r_ek[RUN_AW-1:0]),
        .o_rdata (w_run_rdata)
    );

    lcrv_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (r_sqx + r_sqy),
        .o_busy     (w_sq_busy),
        .o_root     (w_root)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_func == FUNC_POINT)) begin
                    n_state = S_SQ_ADD;
                end
            end
            S_SQ_ADD: begin
                n_state = S_ITER;
            end
            S_ITER: begin
                if (!w_sq_busy && w_g_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (w_join) begin
                    n_state = r_last ? S_EMIT_RD : S_IDLE;
                end else if (r_have) begin
                    n_state = S_EMIT_RD;
                end else begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = (r_last && r_emit2) ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                if (w_out_free) begin
                    n_state = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                if (w_ek_end) begin
                    n_state = r_after ? S_START : S_IDLE;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall  = 1'b1;
        w_sq_start  = 1'b0;
        w_run_we    = 1'b0;
        w_run_waddr = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_SQ_ADD: begin
                w_sq_start = 1'b1;
            end
            S_DECIDE: begin
                w_run_we    = w_join;
                w_run_waddr = r_len[RUN_AW-1:0];
            end
            S_START: begin
                w_run_we = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr   <= THR_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    // Point capture and gap walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpend <= 1'b0;
        end else begin
            r_gpend <= w_g_issue;
        end
        if (w_in_acc) begin
            r_row  <= i_row;
            r_id   <= i_point_id;
            r_z    <= i_z_mm;
            r_last <= i_last_in_column;
            r_sqx  <= unsigned'(w_x2);
            r_sqy  <= unsigned'(w_y2);
            r_gk   <= {1'b0, r_ref_row};
            r_gsum <= '0;
        end else begin
            if (w_g_issue) begin
                r_gk    <= r_gk + 1'b1;
                r_gzero <= (32'(r_gk) >= ROWS);
            end
            if (r_gpend) begin
                r_gsum <= w_gadd[GAP_W] ? GAP_SAT : w_gadd[GAP_W-1:0];
            end
        end
    end

    // Run state and emission.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ref_row   <= '0;
            r_ref_range <= '0;
            r_hmax      <= '0;
            r_hmin      <= '0;
            r_have      <= 1'b0;
            r_ek        <= '0;
            r_emit2     <= 1'b0;
            r_after     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_DECIDE: begin
                    r_ek <= '0;
                    if (w_join) begin
                        r_len       <= r_len + 1'b1;
                        r_ref_row   <= r_row;
                        r_ref_range <= w_root;
                        if (r_z > r_hmax) begin
                            r_hmax <= r_z;
                        end
                        if (r_z < r_hmin) begin
                            r_hmin <= r_z;
                        end
                        r_emit2 <= 1'b0;
                        r_after <= 1'b0;
                    end else begin
                        // A closed run of a full burst leaves no room for the new point.
                        r_emit2 <= r_last && (r_len < LEN_W'(RUN_DEPTH));
                        r_after <= 1'b1;
                    end
                end
                S_START: begin
                    r_ek    <= '0;
                    r_emit2 <= 1'b0;
                    r_after <= 1'b0;
                    if (r_last && !r_emit2) begin
                        r_len       <= '0;
                        r_ref_row   <= '0;
                        r_ref_range <= '0;
                        r_hmax      <= '0;
                        r_hmin      <= '0;
                        r_have      <= 1'b0;
                    end else begin
                        r_len       <= LEN_W'(1);
                        r_ref_row   <= r_row;
                        r_ref_range <= w_root;
                        r_hmax      <= r_z;
                        r_hmin      <= r_z;
                        r_have      <= 1'b1;
                    end
                end
                S_EMIT_LD: begin
                    r_out_valid <= 1'b1;
                    r_out_id    <= w_run_rdata;
                    r_out_vert  <= w_vert;
                    r_out_last  <= w_final;
                    r_ek        <= r_ek + 1'b1;
                    if (w_ek_end && !r_after) begin
                        r_len       <= '0;
                        r_ref_row   <= '0;
                        r_ref_range <= '0;
                        r_hmax      <= '0;
                        r_hmin      <= '0;
                        r_have      <= 1'b0;
                    end
                end
                default: begin
                    r_ek <= r_ek;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_point_id_res = r_out_id;
    assign o_is_vertical  = r_out_vert;
    assign o_last_of_run  = r_out_last;
endmodule
`default_nettype wire

/* test/lcrv_checker.sv */
// Checker for the lidar column ring vertical filter: predicts results and compares them.
`timescale 1ns / 1ps
module lcrv_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_stall,
    input  wire logic                                i_func,
    input  wire logic [lcrv_pkg::ROW_W-1:0]          i_row,
    input  wire logic [lcrv_pkg::GAP_W-1:0]          i_gap_mm,
    input  wire logic [lcrv_pkg::ID_W-1:0]           i_point_id,
    input  wire logic signed [lcrv_pkg::COORD_W-1:0] i_x_mm,
    input  wire logic signed [lcrv_pkg::COORD_W-1:0] i_y_mm,
    input  wire logic signed [lcrv_pkg::COORD_W-1:0] i_z_mm,
    input  wire logic                                i_last_in_column,
    input  wire logic                                i_cfg_we,
    input  wire logic [lcrv_pkg::THR_W-1:0]          i_cfg_wdata,
    input  wire logic                                i_out_valid,
    input  wire logic                                i_out_stall,
    input  wire logic [lcrv_pkg::ID_W-1:0]           i_point_id_res,
    input  wire logic                                i_is_vertical,
    input  wire logic                                i_last_of_run,
    output int                                       o_fail_count,
    output int                                       o_pending,
    output int                                       o_checked
);
    import lcrv_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            vert;
        logic            last;
    } t_flag;

    t_flag                  flags_due[$];
    logic [THR_W-1:0]       threshold;
    logic [GAP_W-1:0]       gaps[RUN_DEPTH];
    logic [ID_W-1:0]        run_pts[RUN_DEPTH];
    int unsigned            run_len;
    logic [ROW_W-1:0]       anchor_row;
    logic [ROOT_W-1:0]      anchor_range;
    int                     z_hi;
    int                     z_lo;
    logic                   anchored;

    function automatic logic [ROOT_W-1:0] horiz_range(int x, int y);
        longint unsigned v;
        longint unsigned res;
        longint unsigned b;
        v = longint'(x) * x + longint'(y) * y;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[ROOT_W-1:0];
    endfunction

    function automatic int unsigned gap_span(int unsigned from, int unsigned upto);
        int unsigned s;
        s = 0;
        for (int unsigned k = from; k < upto; k++) begin
            if (k < RUN_DEPTH) s += gaps[k];
            if (s > GAP_SAT) s = GAP_SAT;
        end
        return s;
    endfunction

    // Queue the points of the open run, up to room of them; returns how many were queued.
    function automatic int flush_run(int room);
        bit vert;
        int n;
        n = 0;
        vert = run_len > 1 && (longint'(z_hi) - longint'(z_lo) > longint'(threshold));
        for (int unsigned k = 0; k < run_len && k < RUN_DEPTH && n < room; k++) begin
            flags_due.insert(flags_due.size(), '{id: run_pts[k], vert: vert, last: 1'b0});
            n++;
        end
        return n;
    endfunction

    task automatic open_run(logic [ID_W-1:0] id, logic [ROW_W-1:0] row,
                            logic [ROOT_W-1:0] r, int z);
        run_pts[0] = id;
        run_len = 1;
        anchor_row = row;
        anchor_range = r;
        z_hi = z;
        z_lo = z;
        anchored = 1'b1;
    endtask

    task automatic predict_point();
        logic [ROOT_W-1:0] r;
        int unsigned diff;
        int z;
        int n;
        r = horiz_range(int'(i_x_mm), int'(i_y_mm));
        z = int'(i_z_mm);
        n = 0;
        if (!anchored) begin
            open_run(i_point_id, i_row, r, z);
        end else begin
            diff = anchor_range > r ? anchor_range - r : r - anchor_range;
            if (diff < gap_span(anchor_row, i_row) && run_len < RUN_DEPTH) begin
                run_pts[run_len] = i_point_id;
                run_len++;
                if (z > z_hi) z_hi = z;
                if (z < z_lo) z_lo = z;
                anchor_range = r;
                anchor_row = i_row;
            end else begin
                n = flush_run(64);
                open_run(i_point_id, i_row, r, z);
            end
        end
        if (i_last_in_column) begin
            // The lone closing point is dropped when the burst is already full.
            n += flush_run(64 - n);
            run_len = 0;
            anchored = 1'b0;
            anchor_row = '0;
            anchor_range = '0;
            z_hi = 0;
            z_lo = 0;
        end
        if (n > 0) flags_due[$].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_flag want;
        if (!i_rst_n) begin
            threshold <= THR_RESET;
            run_len = 0;
            anchored = 1'b0;
            anchor_row = '0;
            anchor_range = '0;
            z_hi = 0;
            z_lo = 0;
            flags_due.delete();
            o_fail_count <= 0;
            o_checked <= 0;
        end else begin
            if (i_cfg_we) threshold <= i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                if (i_func == FUNC_LOAD) gaps[i_row] = i_gap_mm;
                else predict_point();
            end
            if (i_out_valid && !i_out_stall) begin
                o_checked <= o_checked + 1;
                if (flags_due.size() == 0) begin
                    $display("%0t: unexpected result id=%0d vert=%0b last=%0b", $time,
                             i_point_id_res, i_is_vertical, i_last_of_run);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = flags_due.pop_front();
                    if (want.id !== i_point_id_res || want.vert !== i_is_vertical ||
                        want.last !== i_last_of_run) begin
                        $display("%0t: mismatch expected id=%0d vert=%0b last=%0b, got id=%0d vert=%0b last=%0b",
                                 $time, want.id, want.vert, want.last,
                                 i_point_id_res, i_is_vertical, i_last_of_run);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= flags_due.size();
    end
endmodule

/* test/tb_lidar_column_ring_vertical_filter.sv */
// Testbench top for the lidar column ring vertical filter: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_lidar_column_ring_vertical_filter;
    import lcrv_pkg::*;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       func = FUNC_LOAD;
    logic [ROW_W-1:0]           row = '0;
    logic [GAP_W-1:0]           gap_mm = '0;
    logic [ID_W-1:0]            point_id = '0;
    logic signed [COORD_W-1:0]  x_mm = '0;
    logic signed [COORD_W-1:0]  y_mm = '0;
    logic signed [COORD_W-1:0]  z_mm = '0;
    logic                       last_in_column = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [THR_W-1:0]           cfg_wdata = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [ID_W-1:0]            point_id_res;
    logic                       is_vertical;
    logic                       last_of_run;

    int                         fail_count;
    int                         pending;
    int                         checked;

    // Idle mix: percent of cycles the sender idles and the receiver stalls.
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;
    logic                       long_hold_req = 1'b0;
    logic                       long_hold_done = 1'b0;
    int                         long_hold_left = 0;
    int                         transfers_in = 0;
    logic [ID_W-1:0]            next_id = '0;

    lidar_column_ring_vertical_filter #(.ROWS(64)) dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_func(func), .i_row(row), .i_gap_mm(gap_mm), .i_point_id(point_id),
        .i_x_mm(x_mm), .i_y_mm(y_mm), .i_z_mm(z_mm), .i_last_in_column(last_in_column),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_point_id_res(point_id_res), .o_is_vertical(is_vertical),
        .o_last_of_run(last_of_run)
    );

    lcrv_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func), .i_row(row), .i_gap_mm(gap_mm), .i_point_id(point_id),
        .i_x_mm(x_mm), .i_y_mm(y_mm), .i_z_mm(z_mm), .i_last_in_column(last_in_column),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_point_id_res(point_id_res), .i_is_vertical(is_vertical),
        .i_last_of_run(last_of_run),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still expected.", pending);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up
    // into its input channel while the sender keeps offering transfers.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (long_hold_left != 0) begin
            out_stall <= 1'b1;
            long_hold_left <= long_hold_left - 1;
        end else if (long_hold_req && !long_hold_done) begin
            out_stall <= 1'b1;
            long_hold_left <= 1500;
            long_hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // One input transfer. Valid stays high into the next call unless the
    // sender decides to idle, so back-to-back transfers need no dead cycle.
    task automatic offer(logic f, logic [ROW_W-1:0] r, logic [GAP_W-1:0] g,
                         logic [ID_W-1:0] id, int x, int y, int z, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        row <= r;
        gap_mm <= g;
        point_id <= id;
        x_mm <= COORD_W'(x);
        y_mm <= COORD_W'(y);
        z_mm <= COORD_W'(z);
        last_in_column <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        transfers_in++;
    endtask

    task automatic load_gap(int r, int g);
        offer(FUNC_LOAD, ROW_W'(r), GAP_W'(g), ID_W'($urandom), $urandom, $urandom,
              $urandom, 1'($urandom));
    endtask

    task automatic point(int r, int x, int y, int z, logic last);
        offer(FUNC_POINT, ROW_W'(r), GAP_W'($urandom), next_id, x, y, z, last);
        next_id++;
    endtask

    // Let the block drain completely, including any point still in flight
    // that causes no result, before touching the threshold register.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // A plausible column: rising rows and ranges, so runs join and break.
    task automatic column(int len);
        int r;
        int x;
        int y;
        int z;
        r = $urandom_range(8);
        x = $urandom_range(20000, 1000);
        y = int'($urandom_range(6000)) - 3000;
        z = int'($urandom_range(4000)) - 2000;
        if ($urandom_range(1)) x = -x;
        for (int k = 0; k < len; k++) begin
            point(r, x, y, z, k == len - 1);
            // Mostly a step up; sometimes the same row, which always breaks the run.
            if ($urandom_range(99) >= 8) r += $urandom_range(2, 1);
            x += (x < 0 ? -1 : 1) * int'($urandom_range(2600));
            z += ($urandom_range(99) < 15) ? int'($urandom_range(1200)) - 600
                                           : int'($urandom_range(120)) - 60;
        end
    endtask

    // Mostly well-formed columns, some noise points and table rewrites.
    task automatic random_phase(int items);
        int done;
        int len;
        done = 0;
        while (done < items) begin
            if ($urandom_range(99) < 8) begin
                if ($urandom_range(3) == 0) load_gap($urandom_range(63), $urandom);
                else load_gap($urandom_range(63), $urandom_range(3000, 300));
            end else if ($urandom_range(99) < 12) begin
                point($urandom_range(63), int'($urandom << 13) >>> 13,
                      int'($urandom << 13) >>> 13, int'($urandom << 13) >>> 13,
                      1'($urandom_range(1)));
                done++;
            end else begin
                len = $urandom_range(12, 1);
                column(len);
                done += len;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole gap table before any point can read it.
        for (int k = 0; k < 64; k++) load_gap(k, 1000);

        // Directed: lone point, close at column end, extremes of every field.
        point(3, 5000, 0, 0, 1'b1);
        point(2, 4000, 0, -262144, 1'b0);
        point(4, 4500, 0, 262143, 1'b0);
        point(5, 4600, 0, 0, 1'b0);
        point(5, 4600, 0, 0, 1'b0);
        point(6, 90000, 0, 0, 1'b1);
        point(0, -262144, -262144, 10, 1'b0);
        point(63, 262143, 262143, 20, 1'b1);
        offer(FUNC_POINT, 6'd1, '1, '1, 0, 0, 0, 1'b1);
        offer(FUNC_POINT, 6'd1, '0, '0, 0, -1, 0, 1'b1);
        load_gap(10, 0);
        load_gap(11, 20'hFFFFF);
        point(10, 3000, 100, 0, 1'b0);
        point(11, 3000, 100, 50, 1'b0);
        point(12, 200000, 100, 90, 1'b1);
        load_gap(10, 1000);
        load_gap(11, 1000);
        drain();

        write_threshold(16'd0);
        random_phase(40);
        drain();

        send_idle_pct = 60;
        write_threshold(16'hFFFF);
        random_phase(40);
        drain();

        // Overfull burst: 64 joined points, then a closing last point that
        // only flushes the full run.
        send_idle_pct = 0;
        recv_stall_pct = 60;
        write_threshold(16'd300);
        for (int k = 0; k < 64; k++) point(k, 7000, 0, k * 10, 1'b0);
        point(0, 100, 0, 0, 1'b1);
        random_phase(40);
        drain();

        send_idle_pct = 38;
        recv_stall_pct = 38;
        write_threshold(THR_W'($urandom));
        random_phase(40);
        drain();

        // Long receiver hold-off while the sender streams with no gaps.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_threshold(16'd80);
        long_hold_req <= 1'b1;
        random_phase(40);
        drain();

        $display("Sent %0d input transfers and checked %0d results", transfers_in, checked);
        $display("across five thresholds, four idle mixes and a long receiver hold-off.");
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
